### design/point_region_clip_filter_unit_assert.svh
// Assertion macros for the point region clip filter.
// No dependencies; expects clk and rst in the including module's scope.
`ifndef POINT_REGION_CLIP_FILTER_UNIT_ASSERT_SVH
`define POINT_REGION_CLIP_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define PRCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prcf assertion failed");

// next-cycle implication
`define PRCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prcf assertion failed");

`endif

### design/prcf_pkg.sv
// Shared types and constants for the point region clip filter.
// No dependencies.
package prcf_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TAG_BITS       = 32;
  localparam int CTRL_BITS      = 3;
  localparam int REG_IDX_BITS   = 3;
  // arithmetic stages ahead of the output register
  localparam int PIPE_DEPTH     = 6;

  localparam int VEC_Y_RESET    = 256;
  localparam int RADIUS_RESET   = 2560;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CONTROL  = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_ORIGIN_Z = 3'd3,
    REG_VEC_X    = 3'd4,
    REG_VEC_Y    = 3'd5,
    REG_VEC_Z    = 3'd6,
    REG_RADIUS   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SHAPE_SPHERE   = 2'd0,
    SHAPE_PLANE    = 2'd1,
    SHAPE_CYLINDER = 2'd2,
    SHAPE_BOX      = 2'd3
  } shape_t;

  typedef struct packed {
    logic sphere_in;
    logic plane_in;
    logic along_in;
    logic box_in;
  } region_flags_t;

endpackage

### design/prcf_vec_stage.sv
// Stages 1 to 3: offset from origin, magnitudes, dot and cross product terms.
// Depends on prcf_pkg.
module prcf_vec_stage
  import prcf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_BITS-1:0]  pos [3],
  input  logic signed [COORD_BITS-1:0]  origin [3],
  input  logic signed [COORD_BITS-1:0]  vec [3],
  input  logic [COORD_BITS-2:0]         radius,
  output logic [2*COORD_BITS-1:0]       dd_term [3],
  output logic signed [2*COORD_BITS+2:0] da,
  output logic [2*COORD_BITS-1:0]       cross_mag [3],
  output logic [2*COORD_BITS-1:0]       aa,
  output logic [2*COORD_BITS-3:0]       r_sq,
  output logic                          box_in
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 1;
  localparam int XW  = 2 * CW + 2;
  localparam int SW  = 2 * CW;
  localparam int AW  = 2 * CW - 1;
  localparam int RW  = 2 * CW - 2;
  localparam int DAW = 2 * CW + 3;

  logic signed [DW-1:0] d [3];
  logic [CW-1:0]        d_abs [3];
  logic [CW-1:0]        a_abs [3];
  logic [CW-1:0]        d_mag [3];
  logic signed [PW-1:0] da_p [3];
  logic signed [PW-1:0] cr_p [3];
  logic signed [PW-1:0] cr_m [3];
  logic [AW-1:0]        aa_p [3];
  logic [RW-1:0]        r_sq2;
  logic signed [XW-1:0] cross_diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // |d| < 2^CW and |a| <= 2^(CW-1), both fit CW unsigned bits
      d_abs[i] = d[i][DW-1] ? CW'(-d[i]) : d[i][CW-1:0];
      a_abs[i] = vec[i][CW-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
      cross_diff[i] = XW'(cr_p[i]) - XW'(cr_m[i]);
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= DW'(pos[i]) - DW'(origin[i]);
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_mag[i] <= d_abs[i];
        da_p[i]  <= PW'(d[i]) * PW'(vec[i]);
        aa_p[i]  <= AW'(a_abs[i]) * AW'(a_abs[i]);
      end
      // d x a, split into the two product terms of each component
      cr_p[0] <= PW'(d[1]) * PW'(vec[2]);
      cr_m[0] <= PW'(d[2]) * PW'(vec[1]);
      cr_p[1] <= PW'(d[2]) * PW'(vec[0]);
      cr_m[1] <= PW'(d[0]) * PW'(vec[2]);
      cr_p[2] <= PW'(d[0]) * PW'(vec[1]);
      cr_m[2] <= PW'(d[1]) * PW'(vec[0]);
      r_sq2   <= RW'(radius) * RW'(radius);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd_term[i]   <= SW'(d_mag[i]) * SW'(d_mag[i]);
        // cross component magnitude stays below 2^(2*CW)
        cross_mag[i] <= cross_diff[i][XW-1] ? SW'(-cross_diff[i])
                                             : cross_diff[i][SW-1:0];
      end
      box_in <= (d_mag[0] <= a_abs[0]) && (d_mag[1] <= a_abs[1]) &&
                (d_mag[2] <= a_abs[2]);
      da     <= DAW'(da_p[0]) + DAW'(da_p[1]) + DAW'(da_p[2]);
      aa     <= SW'(aa_p[0]) + SW'(aa_p[1]) + SW'(aa_p[2]);
      r_sq   <= r_sq2;
    end
  end

endmodule

### design/prcf_wide_stage.sv
// Stages 4 to 6: wide squares of the cross product split into half-width
// partial products, the radius term, and the narrow shape tests. Uses prcf_pkg.
module prcf_wide_stage
  import prcf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [2*COORD_BITS-1:0]        dd_term [3],
  input  logic signed [2*COORD_BITS+2:0] da,
  input  logic [2*COORD_BITS-1:0]        cross_mag [3],
  input  logic [2*COORD_BITS-1:0]        aa,
  input  logic [2*COORD_BITS-3:0]        r_sq,
  input  logic                           box_in,
  output logic [4*COORD_BITS+1:0]        lhs,
  output logic [4*COORD_BITS-3:0]        rhs,
  output region_flags_t                  flags
);

  localparam int CW  = COORD_BITS;
  localparam int SW  = 2 * CW;
  localparam int DAW = 2 * CW + 3;
  localparam int DDW = 2 * CW + 2;
  localparam int DMW = 2 * CW + 1;
  localparam int RW  = 2 * CW - 2;
  localparam int QW  = 4 * CW;
  localparam int LW  = 4 * CW + 2;
  localparam int RHW = 4 * CW - 2;

  logic [DMW-1:0] da_abs;

  logic [DDW-1:0] dd4;
  logic           plane4;
  logic           box4;
  logic [DMW-1:0] da_mag4;
  logic [SW-1:0]  c_hh [3];
  logic [SW-1:0]  c_hl [3];
  logic [SW-1:0]  c_ll [3];
  logic [RW-1:0]  q_hh;
  logic [RW-1:0]  q_hl;
  logic [SW-1:0]  q_lh;
  logic [SW-1:0]  q_ll;
  logic [SW-1:0]  aa4;
  logic [RW-1:0]  r_sq4;

  logic           sphere5;
  logic           plane5;
  logic           along5;
  logic           box5;
  logic [QW-1:0]  csq5 [3];
  logic [RHW-1:0] rhs5;

  assign da_abs = da[DAW-1] ? DMW'(-da) : da[DMW-1:0];

  // stage 4
  always_ff @(posedge clk) begin
    if (adv) begin
      dd4     <= DDW'(dd_term[0]) + DDW'(dd_term[1]) + DDW'(dd_term[2]);
      plane4  <= !da[DAW-1] && (da != '0);
      da_mag4 <= da_abs;
      for (int i = 0; i < 3; i++) begin
        c_hh[i] <= SW'(cross_mag[i][SW-1:CW]) * SW'(cross_mag[i][SW-1:CW]);
        c_hl[i] <= SW'(cross_mag[i][SW-1:CW]) * SW'(cross_mag[i][CW-1:0]);
        c_ll[i] <= SW'(cross_mag[i][CW-1:0]) * SW'(cross_mag[i][CW-1:0]);
      end
      q_hh  <= RW'(r_sq[RW-1:CW]) * RW'(aa[SW-1:CW]);
      q_hl  <= RW'(r_sq[RW-1:CW]) * RW'(aa[CW-1:0]);
      q_lh  <= SW'(r_sq[CW-1:0]) * SW'(aa[SW-1:CW]);
      q_ll  <= SW'(r_sq[CW-1:0]) * SW'(aa[CW-1:0]);
      aa4   <= aa;
      r_sq4 <= r_sq;
      box4  <= box_in;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (adv) begin
      sphere5 <= dd4 < DDW'(r_sq4);
      along5  <= {da_mag4, 1'b0} < DDW'(aa4);
      for (int i = 0; i < 3; i++) begin
        csq5[i] <= (QW'(c_hh[i]) << SW) + (QW'(c_hl[i]) << (CW + 1)) + QW'(c_ll[i]);
      end
      rhs5   <= (RHW'(q_hh) << SW) + ((RHW'(q_hl) + RHW'(q_lh)) << CW) + RHW'(q_ll);
      plane5 <= plane4;
      box5   <= box4;
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (adv) begin
      lhs             <= LW'(csq5[0]) + LW'(csq5[1]) + LW'(csq5[2]);
      rhs             <= rhs5;
      flags.sphere_in <= sphere5;
      flags.plane_in  <= plane5;
      flags.along_in  <= along5;
      flags.box_in    <= box5;
    end
  end

endmodule

### design/point_region_clip_filter_unit.sv
// Point region clip filter top level: config registers, valid/payload line,
// final region decision and output register. Uses prcf_pkg, both stage modules.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, pos_x/y/z, tag         request in
//   output    out_valid/out_ready, kept_x/y/z, kept_tag request out
//   config    cfg_wr_en, cfg_index, cfg_data            write only
//
// One point per cycle while the output is not stalled; a kept point passes
// through six arithmetic stages, the first loaded at the edge that takes its
// request, then the output register. Dropped points leave a bubble. The
// whole pipeline holds while a result waits on out_ready. Reset clears the
// valid line, out_valid and the config registers to their defaults.
`include "point_region_clip_filter_unit_assert.svh"

module point_region_clip_filter_unit
  import prcf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [TAG_BITS-1:0]          tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] kept_x,
  output logic signed [COORD_BITS-1:0] kept_y,
  output logic signed [COORD_BITS-1:0] kept_z,
  output logic [TAG_BITS-1:0]          kept_tag,
  input  logic                         cfg_wr_en,
  input  logic [REG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int CW  = COORD_BITS;
  localparam int PLW = 3 * CW + TAG_BITS;
  localparam int LW  = 4 * CW + 2;
  localparam int RHW = 4 * CW - 2;

  logic [CTRL_BITS-1:0] ctrl;
  logic signed [CW-1:0] origin [3];
  logic signed [CW-1:0] vec [3];
  logic [CW-2:0]        radius;

  logic signed [CW-1:0] pos [3];
  logic                 adv;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PLW-1:0]       pl_pipe [PIPE_DEPTH];

  logic [2*CW-1:0]        dd_term [3];
  logic signed [2*CW+2:0] da;
  logic [2*CW-1:0]        cross_mag [3];
  logic [2*CW-1:0]        aa;
  logic [2*CW-3:0]        r_sq;
  logic                   box_in;
  logic [LW-1:0]          lhs;
  logic [RHW-1:0]         rhs;
  region_flags_t          flags;

  shape_t shape;
  logic   in_region;
  logic   keep;

  assign pos[0]   = pos_x;
  assign pos[1]   = pos_y;
  assign pos[2]   = pos_z;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign shape    = shape_t'(ctrl[1:0]);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= '0;
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      vec[0]    <= '0;
      vec[1]    <= CW'(VEC_Y_RESET);
      vec[2]    <= '0;
      radius    <= (CW-1)'(RADIUS_RESET);
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_CONTROL:  ctrl      <= cfg_data[CTRL_BITS-1:0];
        REG_ORIGIN_X: origin[0] <= cfg_data;
        REG_ORIGIN_Y: origin[1] <= cfg_data;
        REG_ORIGIN_Z: origin[2] <= cfg_data;
        REG_VEC_X:    vec[0]    <= cfg_data;
        REG_VEC_Y:    vec[1]    <= cfg_data;
        REG_VEC_Z:    vec[2]    <= cfg_data;
        REG_RADIUS:   radius    <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  prcf_vec_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_vec (
    .clk       (clk),
    .adv       (adv),
    .pos       (pos),
    .origin    (origin),
    .vec       (vec),
    .radius    (radius),
    .dd_term   (dd_term),
    .da        (da),
    .cross_mag (cross_mag),
    .aa        (aa),
    .r_sq      (r_sq),
    .box_in    (box_in)
  );

  prcf_wide_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_wide (
    .clk       (clk),
    .adv       (adv),
    .dd_term   (dd_term),
    .da        (da),
    .cross_mag (cross_mag),
    .aa        (aa),
    .r_sq      (r_sq),
    .box_in    (box_in),
    .lhs       (lhs),
    .rhs       (rhs),
    .flags     (flags)
  );

  always_comb begin
    case (shape)
      SHAPE_SPHERE:   in_region = flags.sphere_in;
      SHAPE_PLANE:    in_region = flags.plane_in;
      SHAPE_CYLINDER: in_region = flags.along_in && (lhs < LW'(rhs));
      SHAPE_BOX:      in_region = flags.box_in;
      default:        in_region = 1'b0;
    endcase
    keep = in_region ^ ctrl[2];
  end

  // valid line alongside the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE_DEPTH-2:0], in_valid};
      out_valid <= vld[PIPE_DEPTH-1] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_pipe[0] <= {pos_x, pos_y, pos_z, tag};
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        pl_pipe[k] <= pl_pipe[k-1];
      end
      if (vld[PIPE_DEPTH-1] && keep) begin
        {kept_x, kept_y, kept_z, kept_tag} <= pl_pipe[PIPE_DEPTH-1];
      end
    end
  end

  `PRCF_ASSERT_NXT(a_enter, in_valid && in_ready, vld[0])
  `PRCF_ASSERT_NXT(a_hold, out_valid && !out_ready, $stable(vld) && out_valid)
  `PRCF_ASSERT_NXT(a_emit, vld[PIPE_DEPTH-1] && adv && keep, out_valid)

endmodule

### verif/prcf_clip_checker.sv
// Scoreboard for the point region clip filter: tracks the config registers,
// predicts which requested points are kept and compares the output stream.
// Depends on prcf_pkg.
module prcf_clip_checker
  import prcf_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [CB-1:0] pos_x,
  input  logic signed [CB-1:0] pos_y,
  input  logic signed [CB-1:0] pos_z,
  input  logic [TAG_BITS-1:0]  tag,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [CB-1:0] kept_x,
  input  logic signed [CB-1:0] kept_y,
  input  logic signed [CB-1:0] kept_z,
  input  logic [TAG_BITS-1:0]  kept_tag,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [CB-1:0]        cfg_data,
  output int                   fail_count,
  output int                   pending
);

  // wide enough for |d|^2 * |a|^2 at full coordinate range
  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic [TAG_BITS-1:0]  t;
  } point_t;

  logic [CTRL_BITS-1:0] ctrl_r;
  logic signed [CB-1:0] org_r [3];
  logic signed [CB-1:0] axis_r [3];
  logic [CB-2:0]        rad_r;
  point_t               due_q [$];

  function automatic acc_t mag(acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit region_keeps(point_t p);
    acc_t d [3];
    acc_t a [3];
    acc_t r, dd, da, aa;
    bit enclosed;
    d[0] = acc_t'($signed(p.x)) - acc_t'(org_r[0]);
    d[1] = acc_t'($signed(p.y)) - acc_t'(org_r[1]);
    d[2] = acc_t'($signed(p.z)) - acc_t'(org_r[2]);
    for (int i = 0; i < 3; i++) a[i] = acc_t'(axis_r[i]);
    r  = acc_t'(rad_r);
    dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    da = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
    aa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (shape_t'(ctrl_r[1:0]))
      SHAPE_SPHERE: begin
        enclosed = dd < r * r;
      end
      SHAPE_PLANE: begin
        enclosed = da > 0;
      end
      SHAPE_CYLINDER: begin
        // within the slab along the axis, then lateral distance against r
        enclosed = (mag(da) + mag(da) < aa) && (dd * aa - da * da < r * r * aa);
      end
      default: begin
        enclosed = 1'b1;
        for (int i = 0; i < 3; i++)
          if (mag(d[i]) > mag(a[i])) enclosed = 1'b0;
      end
    endcase
    return enclosed != ctrl_r[2];
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    point_t want, seen;
    if (rst) begin
      ctrl_r     = '0;
      org_r      = '{default: '0};
      axis_r     = '{'0, CB'(VEC_Y_RESET), '0};
      rad_r      = (CB-1)'(RADIUS_RESET);
      fail_count = 0;
      due_q.delete();
    end else begin
      // retire first so a same-edge request never matches itself
      if (out_valid && out_ready) begin
        seen = {kept_x, kept_y, kept_z, kept_tag};
        if (due_q.size() == 0) begin
          $display("%0t: kept point expected none got (%0d,%0d,%0d) tag %h",
                   $time, seen.x, seen.y, seen.z, seen.t);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          check_field("kept_x", $signed(want.x), $signed(seen.x));
          check_field("kept_y", $signed(want.y), $signed(seen.y));
          check_field("kept_z", $signed(want.z), $signed(seen.z));
          check_field("kept_tag", want.t, seen.t);
        end
      end
      if (in_valid && in_ready) begin
        seen = {pos_x, pos_y, pos_z, tag};
        if (region_keeps(seen)) due_q = {due_q, seen};
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CONTROL:  ctrl_r    = cfg_data[CTRL_BITS-1:0];
          REG_ORIGIN_X: org_r[0]  = cfg_data;
          REG_ORIGIN_Y: org_r[1]  = cfg_data;
          REG_ORIGIN_Z: org_r[2]  = cfg_data;
          REG_VEC_X:    axis_r[0] = cfg_data;
          REG_VEC_Y:    axis_r[1] = cfg_data;
          REG_VEC_Z:    axis_r[2] = cfg_data;
          REG_RADIUS:   rad_r     = cfg_data[CB-2:0];
          default: ;
        endcase
      end
    end
    pending = due_q.size();
  end

endmodule

### verif/tb_point_region_clip_filter_unit.sv
// Testbench top for the point region clip filter: clock, reset, point
// requests, region programming and output back-pressure; verdict from the
// scoreboard count. Depends on prcf_pkg, prcf_clip_checker and the block.
module tb_point_region_clip_filter_unit;
  import prcf_pkg::*;

  localparam int CB                = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT       = 100000;
  localparam int REGIONS_PER_PHASE = 9;
  localparam int POINTS_PER_REGION = 24;
  localparam int SETTLE_CYCLES     = 2 * PIPE_DEPTH + 8;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [CB-1:0]    pos_x, pos_y, pos_z;
  logic [TAG_BITS-1:0]     tag;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CB-1:0]    kept_x, kept_y, kept_z;
  logic [TAG_BITS-1:0]     kept_tag;
  logic                    cfg_wr_en;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [CB-1:0]           cfg_data;

  int check_fails;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;

  point_region_clip_filter_unit #(.COORD_BITS(CB)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_x(kept_x), .kept_y(kept_y), .kept_z(kept_z), .kept_tag(kept_tag),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prcf_clip_checker #(.CB(CB)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_x(kept_x), .kept_y(kept_y), .kept_z(kept_z), .kept_tag(kept_tag),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(check_fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_region_clip_filter_unit test failed");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    bit hold_off_done;
    hold_off_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [CB-1:0] rand_span(int n);
    int v;
    v = int'($urandom_range(0, 2 ** (n + 1))) - 2 ** n;
    return v[CB-1:0];
  endfunction

  // returns just after the accepting edge; valid stays up for a follow-on
  task automatic send_point(input logic signed [CB-1:0] x, y, z,
                            input logic [TAG_BITS-1:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    tag      <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop the request line and let in-flight points, dropped ones too, drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [CB-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic program_region(input shape_t shp, input bit inv,
                                input logic [CB-1:0] ox, oy, oz, vx, vy, vz,
                                input logic [CB-1:0] rad);
    logic [CB-1:0] word;
    settle();
    // unused upper bits get noise; the block must ignore them
    word = CB'($urandom);
    word[CTRL_BITS-1:0] = {inv, shp};
    put_reg(REG_CONTROL, word);
    put_reg(REG_ORIGIN_X, ox);
    put_reg(REG_ORIGIN_Y, oy);
    put_reg(REG_ORIGIN_Z, oz);
    put_reg(REG_VEC_X, vx);
    put_reg(REG_VEC_Y, vy);
    put_reg(REG_VEC_Z, vz);
    word = rad;
    word[CB-1] = 1'($urandom_range(1));
    put_reg(REG_RADIUS, word);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int pick, s;
    bit inv;
    shape_t shp;
    logic signed [CB-1:0] o [3];
    logic signed [CB-1:0] v [3];
    logic signed [CB-1:0] pt [3];
    logic [CB-1:0] rad;

    rst           = 1'b1;
    in_valid      = 1'b0;
    pos_x         = '0;
    pos_y         = '0;
    pos_z         = '0;
    tag           = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_CONTROL;
    cfg_data      = '0;
    send_idle_pct = 23;
    recv_idle_pct = 56;
    hold_off_req  = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset region: sphere of radius 2560 round the origin, surface is outside
    send_point(0, 0, 0, 32'h0000_0000);
    send_point(2560, 0, 0, 32'hFFFF_FFFF);
    send_point(0, -2559, 0, 32'h5A5A_A5A5);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 32'h8000_0001);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 32'h7FFF_FFFE);

    // zero plane normal: nothing in front, everything once inverted
    program_region(SHAPE_PLANE, 1'b0, 0, 0, 0, 0, 0, 0, 0);
    send_point(5, 5, 5, 32'h1);
    program_region(SHAPE_PLANE, 1'b1, 0, 0, 0, 0, 0, 0, 0);
    send_point(5, 5, 5, 32'h2);

    // points on the plane are behind it
    program_region(SHAPE_PLANE, 1'b0, 0, 0, 100, 0, 0, 1, 0);
    send_point(0, 0, 101, 32'h3);
    send_point(0, 0, 100, 32'h4);
    send_point(0, 0, 99, 32'h5);

    // zero cylinder axis
    program_region(SHAPE_CYLINDER, 1'b0, 0, 0, 0, 0, 0, 0, 256);
    send_point(0, 0, 0, 32'h6);
    program_region(SHAPE_CYLINDER, 1'b1, 0, 0, 0, 0, 0, 0, 256);
    send_point(0, 0, 0, 32'h7);

    // cylinder along z, both end caps and the mantle are outside
    program_region(SHAPE_CYLINDER, 1'b0, 0, 0, 0, 0, 0, 2560, 256);
    send_point(0, 0, 1279, 32'h8);
    send_point(0, 0, -1280, 32'h9);
    send_point(255, 0, 0, 32'hA);
    send_point(0, 256, 0, 32'hB);

    // box with negative and zero half-extents, faces are inside
    program_region(SHAPE_BOX, 1'b0, 0, 0, 0, -256, 0, COORD_MIN, 0);
    send_point(256, 0, COORD_MIN, 32'hC);
    send_point(-257, 0, 0, 32'hD);
    send_point(0, 1, 0, 32'hE);

    // register extremes, inverted sphere
    program_region(SHAPE_SPHERE, 1'b1, COORD_MIN, COORD_MAX, COORD_MIN,
                   COORD_MAX, COORD_MIN, COORD_MAX, {1'b0, {(CB-1){1'b1}}});
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 32'hF);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 32'h10);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 23 : 0;
      for (int seg = 0; seg < REGIONS_PER_PHASE; seg++) begin
        s = $urandom_range(8, 20);
        if (phase == 2 && seg == 0) begin
          // near-whole-space box so the stalled output backs up the pipe
          s = 22;
          o = '{default: '0};
          program_region(SHAPE_BOX, 1'b0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                         CB'($urandom));
          hold_off_req = 1'b1;
        end else begin
          shp = (phase == 0 && seg < 4) ? shape_t'(seg) : shape_t'($urandom_range(3));
          inv = 1'($urandom_range(1));
          if (seg == REGIONS_PER_PHASE - 1) begin
            for (int i = 0; i < 3; i++) begin
              o[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
              v[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            end
            rad = $urandom_range(1) ? '0 : {1'b0, {(CB-1){1'b1}}};
            s = 22;
          end else begin
            for (int i = 0; i < 3; i++) begin
              o[i] = rand_span(22);
              v[i] = rand_span(s);
            end
            rad = CB'($urandom_range(0, 2 ** s));
          end
          program_region(shp, inv, o[0], o[1], o[2], v[0], v[1], v[2], rad);
        end
        for (int k = 0; k < POINTS_PER_REGION; k++) begin
          pick = $urandom_range(99);
          for (int i = 0; i < 3; i++) begin
            if (pick < 3)
              pt[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            else if (pick < 18)
              pt[i] = CB'($urandom);
            else
              pt[i] = o[i] + rand_span(s + 1);
          end
          send_point(pt[0], pt[1], pt[2], $urandom);
        end
      end
    end

    settle();
    if (check_fails == 0) begin
      $display("point_region_clip_filter_unit test passed");
    end else begin
      $display("point_region_clip_filter_unit test failed");
    end
    $finish;
  end

endmodule
